@@ hdl/ommf_pkg.sv @@
// Shared definitions for the 3x3 occupancy majority filter.
// Holds sizes, class and register codes, and the job record passed front to back.
// No dependencies.
`default_nettype none

package ommf_pkg;

    // Grid limits and field widths
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int COORD_W  = $clog2(MAX_COLS);
    localparam int CFG_W    = 9;
    localparam int CLS_W    = 2;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result slots of one job, in delivery order
    localparam int NRES      = 4;
    localparam int SLOT_A_LO = 0;  // row above, previous column
    localparam int SLOT_A_HI = 1;  // row above, current column
    localparam int SLOT_B_LO = 2;  // current row, previous column
    localparam int SLOT_B_HI = 3;  // current row, current column

    typedef enum logic [CLS_W-1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_FREE    = 2'd1,
        CLS_OCC     = 2'd2,
        CLS_OTHER   = 2'd3
    } t_cls;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    // Up to four decided results produced by one input cell
    typedef struct packed {
        logic [COORD_W-1:0]            row;
        logic [COORD_W-1:0]            col;
        logic [NRES-1:0]               mask;
        logic [NRES-1:0][CLS_W-1:0]    cls;
    } t_job;

endpackage

`default_nettype wire

@@ hdl/occupancy_majority_filter_3x3_top.sv @@
// 3x3 majority filter over an occupancy grid streamed in raster order.
// Input channel: i_in_valid / o_in_stall with i_cell_class (0 unknown, 1 free,
//   2 occupied, 3 other); one cell per accepted request.
// Output channel: o_out_valid / i_out_stall with class, row, column and a flag on
//   the final cell of the grid.
// Config: i_cfg_we writes grid_rows (index 0) or grid_cols (index 1) from
//   i_cfg_data; any write restarts the frame at row 0, column 0.
// Throughput: one cell per cycle while o_in_stall is low. The result for cell
//   (r,c) is produced when cell (r+1,c+1) arrives and passes through the job
//   queue to the output register, which sends one result per cycle unless
//   i_out_stall holds it, so the last row, with two results per cell and four at
//   its end, runs at the output rate; a four-entry job queue absorbs the excess.
// Reset: clears counters, queue and output valid; grid size returns to 256x256.
//   Line buffers are not cleared and need no sweep.
// Receiver stall: the output register holds; once the queue, with the job in
//   flight, is full, o_in_stall rises and intake pauses until results drain.
// Depends on ommf_pkg, ommf_front, ommf_fifo, ommf_back.
`default_nettype none

module occupancy_majority_filter_3x3_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [ommf_pkg::CLS_W-1:0]   i_cell_class,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [ommf_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [ommf_pkg::CLS_W-1:0]        o_smoothed_class,
    output logic [ommf_pkg::COORD_W-1:0]      o_out_row,
    output logic [ommf_pkg::COORD_W-1:0]      o_out_col,
    output logic                              o_last_of_frame
);
    import ommf_pkg::*;

    logic              push;
    t_job              push_job;
    logic              q_valid;
    t_job              q_job;
    logic              pop;
    logic [QCNT_W-1:0] q_count;

    // Intake, line buffer and decisions
    ommf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cell_class (i_cell_class),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_count    (q_count),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Job queue
    ommf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job),
        .o_count (q_count)
    );

    // Result sender
    ommf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_job          (q_job),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_smoothed_class (o_smoothed_class),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule

`default_nettype wire

@@ hdl/ommf_front.sv @@
// Front end of the majority filter: cell intake, raster counters, line buffer,
// 3x3 window and majority decisions, one job per cell that causes results.
// Depends on ommf_pkg.
`default_nettype none

module ommf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [ommf_pkg::CLS_W-1:0]  i_cell_class,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [ommf_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [ommf_pkg::QCNT_W-1:0] i_q_count,
    output logic                             o_push,
    output ommf_pkg::t_job                   o_job
);
    import ommf_pkg::*;

    localparam int WIN   = 9;
    localparam int CNT_W = $clog2(WIN + 1);

    // One column of the window: two buffered rows and the incoming row
    typedef struct packed {
        logic [CLS_W-1:0] p2;
        logic [CLS_W-1:0] p1;
        logic [CLS_W-1:0] c;
    } t_col;

    // Clamp a register value to a last index: zero means one, large saturates
    function automatic logic [COORD_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                      input int unsigned lim);
        if (v == '0) begin
            return '0;
        end else if (v > CFG_W'(lim)) begin
            return COORD_W'(lim - 1);
        end
        return COORD_W'(v - 1'b1);
    endfunction

    // Rows for a result in the row above the input row
    function automatic logic [3*CLS_W-1:0] rows_above(input t_col k, input logic top_clamp);
        return {(top_clamp ? k.p1 : k.p2), k.p1, k.c};
    endfunction

    // Rows for a result in the input row itself (last row of the grid)
    function automatic logic [3*CLS_W-1:0] rows_last(input t_col k, input logic top_clamp);
        return {(top_clamp ? k.c : k.p1), k.c, k.c};
    endfunction

    // Occupied or free if it strictly outnumbers both other counted classes, unknown otherwise; other counts nowhere
    function automatic logic [CLS_W-1:0] majority(input logic [WIN*CLS_W-1:0] cells);
        logic [WIN-1:0]   hit_unk;
        logic [WIN-1:0]   hit_free;
        logic [WIN-1:0]   hit_occ;
        logic [CNT_W-1:0] cnt_unk;
        logic [CNT_W-1:0] cnt_free;
        logic [CNT_W-1:0] cnt_occ;
        logic [CLS_W-1:0] res;
        for (int k = 0; k < WIN; k++) begin
            hit_unk[k]  = (cells[k*CLS_W +: CLS_W] == CLS_UNKNOWN);
            hit_free[k] = (cells[k*CLS_W +: CLS_W] == CLS_FREE);
            hit_occ[k]  = (cells[k*CLS_W +: CLS_W] == CLS_OCC);
        end
        cnt_unk  = CNT_W'($countones(hit_unk));
        cnt_free = CNT_W'($countones(hit_free));
        cnt_occ  = CNT_W'($countones(hit_occ));
        if (cnt_occ > cnt_free && cnt_occ > cnt_unk) begin
            res = CLS_OCC;
        end else if (cnt_free > cnt_occ && cnt_free > cnt_unk) begin
            res = CLS_FREE;
        end else begin
            res = CLS_UNKNOWN;
        end
        return res;
    endfunction

    logic [2*CLS_W-1:0] r_mem [MAX_COLS];  // {two rows up, one row up} per column
    logic [COORD_W-1:0] r_last_row;
    logic [COORD_W-1:0] r_last_col;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic               r_s1_valid;
    logic [CLS_W-1:0]   r_s1_cls;
    logic [COORD_W-1:0] r_s1_row;
    logic [COORD_W-1:0] r_s1_col;
    logic [2*CLS_W-1:0] r_rd;
    logic               r_fwd;
    logic [2*CLS_W-1:0] r_fwd_data;
    t_col               r_w1;
    t_col               r_w2;

    logic               in_acc;
    t_col               s1_col;
    logic [2*CLS_W-1:0] s1_wdata;
    logic               j_ge1;
    logic               j_is1;
    logic               j_last;
    logic               i_ge1;
    logic               i_is1;
    logic               i_last;
    t_col               lo_l;
    t_col               hi_l;
    logic [NRES-1:0]    mask;

    // Hold off intake unless the queue can take every job already in flight
    assign o_in_stall = ({1'b0, i_q_count} + (QCNT_W + 1)'(r_s1_valid))
                        >= (QCNT_W + 1)'(QDEPTH);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Configuration registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= COORD_W'(MAX_ROWS - 1);
            r_last_col <= COORD_W'(MAX_COLS - 1);
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ROWS: r_last_row <= last_index(i_cfg_data, MAX_ROWS);
                    CFG_COLS: r_last_col <= last_index(i_cfg_data, MAX_COLS);
                    default: ;
                endcase
                r_row <= '0;
                r_col <= '0;
            end else if (in_acc) begin
                if (r_col == r_last_col) begin
                    r_col <= '0;
                    r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Line buffer: read at intake, write back the shifted column in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= s1_wdata;
        end
        if (in_acc) begin
            r_rd <= r_mem[r_col];
        end
    end

    // Capture the cell; flag a same-column write that the read would miss
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cls   <= i_cell_class;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_fwd      <= r_s1_valid && (r_s1_col == r_col);
            r_fwd_data <= s1_wdata;
        end
    end

    assign s1_col   = {(r_fwd ? r_fwd_data : r_rd), r_s1_cls};
    assign s1_wdata = {s1_col.p1, s1_col.c};

    // Advance the window by one column
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_w1 <= s1_col;
            r_w2 <= r_w1;
        end
    end

    // Position flags of the cell in stage one
    assign j_ge1  = (r_s1_col != '0);
    assign j_is1  = (r_s1_col == COORD_W'(1));
    assign j_last = (r_s1_col == r_last_col);
    assign i_ge1  = (r_s1_row != '0);
    assign i_is1  = (r_s1_row == COORD_W'(1));
    assign i_last = (r_s1_row == r_last_row);

    // Left columns with edge replication
    assign lo_l = j_is1 ? r_w1 : r_w2;
    assign hi_l = j_ge1 ? r_w1 : s1_col;

    // Decide up to four results and hand them over as one job
    always_comb begin
        mask[SLOT_A_LO] = i_ge1 && j_ge1;
        mask[SLOT_A_HI] = i_ge1 && j_last;
        mask[SLOT_B_LO] = i_last && j_ge1;
        mask[SLOT_B_HI] = i_last && j_last;

        o_job.row  = r_s1_row;
        o_job.col  = r_s1_col;
        o_job.mask = mask;
        o_job.cls[SLOT_A_LO] = majority({rows_above(lo_l, i_is1), rows_above(r_w1, i_is1),
                                         rows_above(s1_col, i_is1)});
        o_job.cls[SLOT_A_HI] = majority({rows_above(hi_l, i_is1), rows_above(s1_col, i_is1),
                                         rows_above(s1_col, i_is1)});
        o_job.cls[SLOT_B_LO] = majority({rows_last(lo_l, !i_ge1), rows_last(r_w1, !i_ge1),
                                         rows_last(s1_col, !i_ge1)});
        o_job.cls[SLOT_B_HI] = majority({rows_last(hi_l, !i_ge1), rows_last(s1_col, !i_ge1),
                                         rows_last(s1_col, !i_ge1)});
        o_push = r_s1_valid && (|mask);
    end

endmodule

`default_nettype wire

@@ hdl/ommf_fifo.sv @@
// Short job queue that decouples the filter front end from the result sender.
// Depends on ommf_pkg.
`default_nettype none

module ommf_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire ommf_pkg::t_job              i_data,
    input  wire logic                        i_pop,
    output logic                             o_valid,
    output ommf_pkg::t_job                   o_data,
    output logic [ommf_pkg::QCNT_W-1:0]      o_count
);
    import ommf_pkg::*;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_job               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ hdl/ommf_back.sv @@
// Result sender of the majority filter: walks the slots of the head job in order
// and presents one result request per unstalled cycle from an output register.
// Depends on ommf_pkg.
`default_nettype none

module ommf_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire ommf_pkg::t_job               i_q_job,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [ommf_pkg::CLS_W-1:0]        o_smoothed_class,
    output logic [ommf_pkg::COORD_W-1:0]      o_out_row,
    output logic [ommf_pkg::COORD_W-1:0]      o_out_col,
    output logic                              o_last_of_frame
);
    import ommf_pkg::*;

    logic [NRES-1:0]    r_done;
    logic               r_out_valid;
    logic [CLS_W-1:0]   r_smoothed_class;
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;
    logic               r_last_of_frame;

    logic [NRES-1:0]    rem;
    logic [NRES-1:0]    sel;
    logic               load;
    logic [CLS_W-1:0]   sel_cls;
    logic               sel_cur_row;
    logic               sel_cur_col;

    // Pick the lowest slot still to send
    assign rem  = i_q_job.mask & ~r_done;
    assign sel  = rem & (~rem + NRES'(1));
    assign load = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = load && (rem == sel);

    always_comb begin
        sel_cls = '0;
        for (int k = 0; k < NRES; k++) begin
            if (sel[k]) begin
                sel_cls = i_q_job.cls[k];
            end
        end
        sel_cur_row = sel[SLOT_B_LO] || sel[SLOT_B_HI];
        sel_cur_col = sel[SLOT_A_HI] || sel[SLOT_B_HI];
    end

    // Output request valid and slot progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | sel;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_smoothed_class <= sel_cls;
            r_out_row        <= sel_cur_row ? i_q_job.row : i_q_job.row - 1'b1;
            r_out_col        <= sel_cur_col ? i_q_job.col : i_q_job.col - 1'b1;
            r_last_of_frame  <= sel[SLOT_B_HI];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_smoothed_class = r_smoothed_class;
    assign o_out_row        = r_out_row;
    assign o_out_col        = r_out_col;
    assign o_last_of_frame  = r_last_of_frame;

endmodule

`default_nettype wire

@@ hdl/ommf_checker.sv @@
// Port-level checks for the 3x3 majority filter, bound to the top level.
// Depends on ommf_pkg and occupancy_majority_filter_3x3_top.
`default_nettype none

module ommf_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [ommf_pkg::CLS_W-1:0]   o_smoothed_class,
    input wire logic [ommf_pkg::COORD_W-1:0] o_out_row,
    input wire logic [ommf_pkg::COORD_W-1:0] o_out_col,
    input wire logic                         o_last_of_frame
);
    import ommf_pkg::*;

    // Reset leaves no result pending and intake open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall right after reset");

    // A stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smoothed_class)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_frame))
        else $error("stalled result changed");

    // A new frame starts at row zero
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_of_frame |=> !o_out_valid || o_out_row == '0)
        else $error("result after end of frame not in row zero");

    // Unknown, free or occupied only, and no result straight out of reset
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |-> o_smoothed_class != CLS_OTHER && $past(i_rst_n))
        else $error("bad class code or result straight out of reset");

endmodule

bind occupancy_majority_filter_3x3_top ommf_checker u_ommf_checker (.*);

`default_nettype wire
